// File: design/bldcc_pkg.sv
package bldcc_pkg;

   localparam logic [5:0] G_HU = 6'h01;
   localparam logic [5:0] G_HV = 6'h02;
   localparam logic [5:0] G_HW = 6'h04;
   localparam logic [5:0] G_LU = 6'h08;
   localparam logic [5:0] G_LV = 6'h10;
   localparam logic [5:0] G_LW = 6'h20;

   localparam logic [7:0]  DUTY_STEP          = 8'd5;
   localparam logic [7:0]  DUTY_MAX           = 8'd255;
   localparam logic [7:0]  DUTY_UP_LIMIT      = DUTY_MAX - DUTY_STEP;
   localparam logic [7:0]  TARGET_DUTY_RESET  = 8'd100;
   localparam logic        SPIN_DIR_RESET     = 1'b1;
   localparam logic [7:0]  START_DUTY_RESET   = 8'd10;
   localparam logic [7:0]  LOCK_COUNT_RESET   = 8'd200;
   localparam logic [15:0] TIMEOUT_RESET      = 16'd256;
   localparam logic [2:0]  LAST_STEP          = 3'd5;

   typedef enum logic [2:0] {
      CMD_TOGGLE     = 3'd0,
      CMD_TICK       = 3'd1,
      CMD_SPEED_UP   = 3'd2,
      CMD_SPEED_DOWN = 3'd3,
      CMD_RUN        = 3'd4
   } cmd_type;

   typedef enum logic [1:0] {
      CSR_SPIN_DIRECTION = 2'd0,
      CSR_START_DUTY     = 2'd1,
      CSR_LOCK_COUNT     = 2'd2,
      CSR_TIMEOUT_TICKS  = 2'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      PHASE_U = 2'd0,
      PHASE_V = 2'd1,
      PHASE_W = 2'd2
   } phase_type;

   typedef struct packed {
      logic        spin_direction;
      logic [7:0]  start_duty;
      logic [7:0]  lock_count;
      logic [15:0] timeout_ticks;
   } cfg_type;

   typedef struct packed {
      logic [5:0] gates;
      logic [1:0] sense_select;
      logic [2:0] step_now;
      logic [7:0] duty;
      logic       locked;
      logic       stepped;
      logic       running;
   } result_type;

   typedef struct packed {
      logic [5:0] on;
      logic [5:0] off;
      logic [1:0] sense;
   } action_type;

   function automatic action_type step_action(input logic dir, input logic [2:0] step);
      action_type a;
      a = '{on: G_HW, off: G_HU, sense: PHASE_U};
      if (dir) begin
         case (step)
            3'd0:    a = '{on: G_HU, off: G_HW, sense: PHASE_W};
            3'd1:    a = '{on: G_LW, off: G_LV, sense: PHASE_V};
            3'd2:    a = '{on: G_HV, off: G_HU, sense: PHASE_U};
            3'd3:    a = '{on: G_LU, off: G_LW, sense: PHASE_W};
            3'd4:    a = '{on: G_HW, off: G_HV, sense: PHASE_V};
            3'd5:    a = '{on: G_LV, off: G_LU, sense: PHASE_U};
            default: a = '{on: G_HU, off: G_HW, sense: PHASE_W};
         endcase
      end else begin
         case (step)
            3'd0:    a = '{on: G_HW, off: G_HU, sense: PHASE_U};
            3'd1:    a = '{on: G_LU, off: G_LV, sense: PHASE_V};
            3'd2:    a = '{on: G_HV, off: G_HW, sense: PHASE_W};
            3'd3:    a = '{on: G_LW, off: G_LU, sense: PHASE_U};
            3'd4:    a = '{on: G_HU, off: G_HV, sense: PHASE_V};
            3'd5:    a = '{on: G_LV, off: G_LW, sense: PHASE_W};
            default: a = '{on: G_HW, off: G_HU, sense: PHASE_U};
         endcase
      end
      return a;
   endfunction

endpackage

// File: design/bldcc_csr.sv
module bldcc_csr (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [1:0]              csr_index,
   input  logic [15:0]             csr_data,
   output bldcc_pkg::cfg_type      cfg
);
   import bldcc_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            CSR_SPIN_DIRECTION: cfg_in.spin_direction = csr_data[0];
            CSR_START_DUTY:     cfg_in.start_duty     = csr_data[7:0];
            CSR_LOCK_COUNT:     cfg_in.lock_count     = csr_data[7:0];
            CSR_TIMEOUT_TICKS:  cfg_in.timeout_ticks  = csr_data;
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.spin_direction <= SPIN_DIR_RESET;
         cfg_ff.start_duty     <= START_DUTY_RESET;
         cfg_ff.lock_count     <= LOCK_COUNT_RESET;
         cfg_ff.timeout_ticks  <= TIMEOUT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// File: design/bldcc_step.sv
module bldcc_step (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    advance,
   input  logic [2:0]              command,
   input  logic                    comp_level,
   input  bldcc_pkg::cfg_type      cfg,
   output bldcc_pkg::result_type   result
);
   import bldcc_pkg::*;

   logic [2:0]  step_ff,   step_in;
   logic [5:0]  gate_ff,   gate_in;
   logic [1:0]  sense_ff,  sense_in;
   logic [7:0]  pulse_ff,  pulse_in;
   logic [15:0] idle_ff,   idle_in;
   logic [7:0]  target_ff, target_in;
   logic        run_ff,    run_in;

   action_type  act;
   logic        do_step;
   logic [7:0]  pulse_inc;
   logic [15:0] idle_inc;
   logic [7:0]  headroom;
   logic        locked;

   always_comb begin
      act       = step_action(cfg.spin_direction, step_ff);
      pulse_inc = (pulse_ff < cfg.lock_count) ? pulse_ff + 8'd1 : cfg.lock_count;
      idle_inc  = (idle_ff == 16'hFFFF) ? idle_ff : idle_ff + 16'd1;
      headroom  = target_ff - cfg.start_duty;

      step_in   = step_ff;
      gate_in   = gate_ff;
      sense_in  = sense_ff;
      pulse_in  = pulse_ff;
      idle_in   = idle_ff;
      target_in = target_ff;
      run_in    = run_ff;
      do_step   = 1'b0;

      if (command == CMD_RUN) begin
         run_in = !run_ff;
         if (run_ff) begin
            gate_in = '0;
         end
      end else if (run_ff) begin
         case (command)
            CMD_TOGGLE: begin
               pulse_in = pulse_inc;
               do_step  = (pulse_inc == cfg.lock_count) && (comp_level == step_ff[0]);
            end
            CMD_TICK: begin
               idle_in = idle_inc;
               if (idle_inc >= cfg.timeout_ticks) begin
                  pulse_in = '0;
                  do_step  = 1'b1;
               end
            end
            CMD_SPEED_UP: begin
               target_in = (target_ff > DUTY_UP_LIMIT) ? DUTY_MAX : target_ff + DUTY_STEP;
            end
            CMD_SPEED_DOWN: begin
               if (target_ff > cfg.start_duty) begin
                  target_in = (headroom <= DUTY_STEP) ? cfg.start_duty
                                                      : target_ff - DUTY_STEP;
               end
            end
            default: begin
            end
         endcase
      end

      if (do_step) begin
         gate_in  = (gate_ff & ~act.off) | act.on;
         sense_in = act.sense;
         step_in  = (step_ff >= LAST_STEP) ? 3'd0 : step_ff + 3'd1;
         idle_in  = '0;
      end

      locked                = (pulse_in == cfg.lock_count);
      result.gates          = run_in ? gate_in : 6'd0;
      result.sense_select   = sense_in;
      result.step_now       = step_in;
      result.duty           = locked ? target_in : cfg.start_duty;
      result.locked         = locked;
      result.stepped        = do_step;
      result.running        = run_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff   <= '0;
         gate_ff   <= '0;
         sense_ff  <= PHASE_U;
         pulse_ff  <= '0;
         idle_ff   <= '0;
         target_ff <= TARGET_DUTY_RESET;
         run_ff    <= 1'b0;
      end else if (advance) begin
         step_ff   <= step_in;
         gate_ff   <= gate_in;
         sense_ff  <= sense_in;
         pulse_ff  <= pulse_in;
         idle_ff   <= idle_in;
         target_ff <= target_in;
         run_ff    <= run_in;
      end
   end

endmodule

// File: design/sensorless_bldc_six_step_commutator_core.sv
// Six-step sensorless BLDC commutator.
// Request channel (req_valid / req_stall) carries one command beat: comparator
// toggle, time tick, speed up, speed down or run toggle, plus the comparator
// level. Every request beat yields exactly one response beat on rsp_valid /
// rsp_stall with the six gate enables, sensed phase, step, duty, lock, step
// and run flags as they stand after that command.
// An accepted beat waits in the input register, is processed into the response
// register and is taken from there. The input register and the response
// register form a two-deep pipe, so one beat is accepted every cycle as long
// as responses are taken.
// When the receiver stalls, the response register holds; the input register
// then fills and req_stall rises until the response is taken.
// The csr channel writes direction, start duty, lock count and timeout; it is
// always ready and is to be written only while no beat is in flight.
// Synchronous reset restores the register defaults, stops the motor with all
// gates off, step 0, phase U, target duty 100, and empties the pipe.
module sensorless_bldc_six_step_commutator_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_command,
   input  logic        req_comp_level,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_high_u,
   output logic        rsp_high_v,
   output logic        rsp_high_w,
   output logic        rsp_low_u,
   output logic        rsp_low_v,
   output logic        rsp_low_w,
   output logic [1:0]  rsp_sense_select,
   output logic [2:0]  rsp_step_now,
   output logic [7:0]  rsp_duty,
   output logic        rsp_locked,
   output logic        rsp_stepped,
   output logic        rsp_running,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_data
);
   import bldcc_pkg::*;

   cfg_type    cfg;
   result_type result;
   result_type rsp_ff;

   logic       in_valid_ff, in_valid_in;
   logic [2:0] in_cmd_ff;
   logic       in_level_ff;
   logic       out_valid_ff, out_valid_in;
   logic       advance;
   logic       req_take;

   bldcc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   bldcc_step u_step (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .command    (in_cmd_ff),
      .comp_level (in_level_ff),
      .cfg        (cfg),
      .result     (result)
   );

   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
      if (req_take) begin
         in_cmd_ff   <= req_command;
         in_level_ff <= req_comp_level;
      end
      if (advance) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_high_u       = rsp_ff.gates[0];
   assign rsp_high_v       = rsp_ff.gates[1];
   assign rsp_high_w       = rsp_ff.gates[2];
   assign rsp_low_u        = rsp_ff.gates[3];
   assign rsp_low_v        = rsp_ff.gates[4];
   assign rsp_low_w        = rsp_ff.gates[5];
   assign rsp_sense_select = rsp_ff.sense_select;
   assign rsp_step_now     = rsp_ff.step_now;
   assign rsp_duty         = rsp_ff.duty;
   assign rsp_locked       = rsp_ff.locked;
   assign rsp_stepped      = rsp_ff.stepped;
   assign rsp_running      = rsp_ff.running;

`ifndef SYNTHESIS
   a_step_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_step_now <= LAST_STEP))
      else $error("step out of range");

   a_gates_off_stopped: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_running) |-> (rsp_ff.gates == 6'd0))
      else $error("gates on while stopped");

   a_stall_only_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (in_valid_ff && out_valid_ff && rsp_stall))
      else $error("request stalled with room in pipe");

   a_reset_empty: assert property (@(posedge clock)
      (!reset && $past(reset)) |-> (!rsp_valid && !req_stall))
      else $error("pipe not empty after reset");
`endif

endmodule

// File: tb/tb.sv
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import bldcc_pkg::*;

   localparam int         RUN_LIMIT     = 400000;
   localparam int         HOLD_AFTER    = 40;
   localparam int         HOLD_CYCLES   = 150;
   localparam logic [2:0] CMD_LAST_CODE = 3'd7;

   typedef struct packed {
      logic [2:0] command;
      logic       level;
   } cmd_beat_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [2:0]  req_command = CMD_TOGGLE;
   logic        req_comp_level = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_high_u;
   logic        rsp_high_v;
   logic        rsp_high_w;
   logic        rsp_low_u;
   logic        rsp_low_v;
   logic        rsp_low_w;
   logic [1:0]  rsp_sense_select;
   logic [2:0]  rsp_step_now;
   logic [7:0]  rsp_duty;
   logic        rsp_locked;
   logic        rsp_stepped;
   logic        rsp_running;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = CSR_SPIN_DIRECTION;
   logic [15:0] csr_data = 16'd0;

   sensorless_bldc_six_step_commutator_core i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_command      (req_command),
      .req_comp_level   (req_comp_level),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_high_u       (rsp_high_u),
      .rsp_high_v       (rsp_high_v),
      .rsp_high_w       (rsp_high_w),
      .rsp_low_u        (rsp_low_u),
      .rsp_low_v        (rsp_low_v),
      .rsp_low_w        (rsp_low_w),
      .rsp_sense_select (rsp_sense_select),
      .rsp_step_now     (rsp_step_now),
      .rsp_duty         (rsp_duty),
      .rsp_locked       (rsp_locked),
      .rsp_stepped      (rsp_stepped),
      .rsp_running      (rsp_running),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   cfg_type    cfg;
   logic [2:0] m_step;
   logic [5:0] m_gates;
   logic [1:0] m_sense;
   logic [7:0] m_pulses;
   logic [15:0] m_idle;
   logic [7:0] m_target;
   logic       m_run;

   cmd_beat_type cmd_backlog[$];
   result_type pending_outputs[$];
   bit         run_parity = 1'b0;
   int         mismatch_count = 0;
   int         cycle_count = 0;

   function automatic void apply_commutation();
      logic [2:0] s;
      logic [5:0] on_mask;
      logic [5:0] off_mask;
      logic [1:0] next_sense;
      s = (m_step > LAST_STEP) ? 3'd0 : m_step;
      case ({cfg.spin_direction, s})
         {1'b0, 3'd0}: {on_mask, off_mask, next_sense} = {G_HW, G_HU, PHASE_U};
         {1'b0, 3'd1}: {on_mask, off_mask, next_sense} = {G_LU, G_LV, PHASE_V};
         {1'b0, 3'd2}: {on_mask, off_mask, next_sense} = {G_HV, G_HW, PHASE_W};
         {1'b0, 3'd3}: {on_mask, off_mask, next_sense} = {G_LW, G_LU, PHASE_U};
         {1'b0, 3'd4}: {on_mask, off_mask, next_sense} = {G_HU, G_HV, PHASE_V};
         {1'b0, 3'd5}: {on_mask, off_mask, next_sense} = {G_LV, G_LW, PHASE_W};
         {1'b1, 3'd0}: {on_mask, off_mask, next_sense} = {G_HU, G_HW, PHASE_W};
         {1'b1, 3'd1}: {on_mask, off_mask, next_sense} = {G_LW, G_LV, PHASE_V};
         {1'b1, 3'd2}: {on_mask, off_mask, next_sense} = {G_HV, G_HU, PHASE_U};
         {1'b1, 3'd3}: {on_mask, off_mask, next_sense} = {G_LU, G_LW, PHASE_W};
         {1'b1, 3'd4}: {on_mask, off_mask, next_sense} = {G_HW, G_HV, PHASE_V};
         default:      {on_mask, off_mask, next_sense} = {G_LV, G_LU, PHASE_U};
      endcase
      m_gates = (m_gates & ~off_mask) | on_mask;
      m_sense = next_sense;
      m_step  = (s == LAST_STEP) ? 3'd0 : s + 3'd1;
      m_idle  = 16'd0;
   endfunction

   function automatic result_type predict_outputs(input logic [2:0] command, input logic level);
      result_type r;
      logic       stepped;
      stepped = 1'b0;
      if (command == CMD_RUN) begin
         m_run = ~m_run;
         if (!m_run) m_gates = '0;
      end else if (m_run) begin
         case (command)
            CMD_TOGGLE: begin
               if (m_pulses < cfg.lock_count) m_pulses = m_pulses + 8'd1;
               else m_pulses = cfg.lock_count;
               if (m_pulses == cfg.lock_count && level == m_step[0]) begin
                  apply_commutation();
                  stepped = 1'b1;
               end
            end
            CMD_TICK: begin
               if (m_idle != 16'hFFFF) m_idle = m_idle + 16'd1;
               if (m_idle >= cfg.timeout_ticks) begin
                  m_pulses = 8'd0;
                  apply_commutation();
                  stepped = 1'b1;
               end
            end
            CMD_SPEED_UP: begin
               m_target = (m_target > DUTY_UP_LIMIT) ? DUTY_MAX : m_target + DUTY_STEP;
            end
            CMD_SPEED_DOWN: begin
               if (m_target > cfg.start_duty) begin
                  if (m_target - cfg.start_duty <= DUTY_STEP) m_target = cfg.start_duty;
                  else m_target = m_target - DUTY_STEP;
               end
            end
            default: ;
         endcase
      end
      r.gates        = m_run ? m_gates : 6'd0;
      r.sense_select = m_sense;
      r.step_now     = m_step;
      r.locked       = (m_pulses == cfg.lock_count);
      r.duty         = r.locked ? m_target : cfg.start_duty;
      r.stepped      = stepped;
      r.running      = m_run;
      return r;
   endfunction

   // sender: bursts of random length, random gaps
   int        burst_left = 0;
   int        gap_left = 0;
   cmd_beat_type next_beat;

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            pending_outputs.push_back(predict_outputs(req_command, req_comp_level));
         end
         if (!req_valid || !req_stall) begin
            if (burst_left == 0 && gap_left == 0) begin
               burst_left = $urandom_range(1, 24);
               gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            end
            if (burst_left != 0 && cmd_backlog.size() != 0) begin
               next_beat = cmd_backlog.pop_front();
               req_valid      <= 1'b1;
               req_command    <= next_beat.command;
               req_comp_level <= next_beat.level;
               burst_left--;
            end else begin
               req_valid <= 1'b0;
               if (burst_left == 0) gap_left--;
            end
         end
      end
   end

   task automatic check_field(input string name, input int unsigned want, input int unsigned got);
      if (want != got) begin
         $display("%0t %s expected %0d actual %0d", $time, name, want, got);
         mismatch_count++;
      end
   endtask

   // receiver: stall pattern in stretches, one long hold-off to back up the pipe
   int         stretch_left = 0;
   int         stall_pct = 0;
   int         hold_left = 0;
   bit         hold_done = 1'b0;
   int         beats_seen = 0;
   result_type want;

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         beats_seen++;
         if (pending_outputs.size() == 0) begin
            $display("%0t unexpected result beat, step_now %0d", $time, rsp_step_now);
            mismatch_count++;
         end else begin
            want = pending_outputs.pop_front();
            check_field("high_u", want.gates[0], rsp_high_u);
            check_field("high_v", want.gates[1], rsp_high_v);
            check_field("high_w", want.gates[2], rsp_high_w);
            check_field("low_u", want.gates[3], rsp_low_u);
            check_field("low_v", want.gates[4], rsp_low_v);
            check_field("low_w", want.gates[5], rsp_low_w);
            check_field("sense_select", want.sense_select, rsp_sense_select);
            check_field("step_now", want.step_now, rsp_step_now);
            check_field("duty", want.duty, rsp_duty);
            check_field("locked", want.locked, rsp_locked);
            check_field("stepped", want.stepped, rsp_stepped);
            check_field("running", want.running, rsp_running);
         end
      end
      if (hold_left != 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (!hold_done && beats_seen >= HOLD_AFTER) begin
         hold_done = 1'b1;
         hold_left = HOLD_CYCLES;
         rsp_stall <= 1'b1;
      end else begin
         if (stretch_left == 0) begin
            stretch_left = $urandom_range(10, 60);
            case ($urandom_range(0, 5))
               0, 1:    stall_pct = 0;
               2:       stall_pct = 25;
               3:       stall_pct = 50;
               4:       stall_pct = 80;
               default: stall_pct = 100;
            endcase
         end
         stretch_left--;
         rsp_stall <= ($urandom_range(0, 99) < stall_pct);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == RUN_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   task automatic write_csr(input csr_index_type idx, input logic [15:0] data);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         CSR_SPIN_DIRECTION: cfg.spin_direction = data[0];
         CSR_START_DUTY:     cfg.start_duty     = data[7:0];
         CSR_LOCK_COUNT:     cfg.lock_count     = data[7:0];
         default:            cfg.timeout_ticks  = data;
      endcase
   endtask

   task automatic program_commutator(input logic dir, input logic [7:0] start,
                                     input logic [7:0] lock, input logic [15:0] limit);
      write_csr(CSR_SPIN_DIRECTION, {15'd0, dir});
      write_csr(CSR_START_DUTY, {8'd0, start});
      write_csr(CSR_LOCK_COUNT, {8'd0, lock});
      write_csr(CSR_TIMEOUT_TICKS, limit);
      @(negedge clock);
   endtask

   task automatic queue_cmd(input logic [2:0] command, input logic level);
      cmd_backlog.push_back(cmd_beat_type'{command: command, level: level});
      if (command == CMD_RUN) run_parity = ~run_parity;
   endtask

   task automatic queue_random_items(input int count, input int toggle_pct,
                                     input int up_pct, input int down_pct);
      int r;
      repeat (count) begin
         r = $urandom_range(0, 99);
         if (!run_parity) begin
            if (r < 70) queue_cmd(CMD_RUN, 1'($urandom_range(0, 1)));
            else queue_cmd(3'($urandom_range(0, CMD_LAST_CODE)), 1'($urandom_range(0, 1)));
         end else if (r < toggle_pct) begin
            queue_cmd(CMD_TOGGLE, 1'($urandom_range(0, 1)));
         end else if (r < toggle_pct + up_pct) begin
            queue_cmd(CMD_SPEED_UP, 1'($urandom_range(0, 1)));
         end else if (r < toggle_pct + up_pct + down_pct) begin
            queue_cmd(CMD_SPEED_DOWN, 1'($urandom_range(0, 1)));
         end else if (r < 95) begin
            queue_cmd(CMD_TICK, 1'($urandom_range(0, 1)));
         end else if (r < 97) begin
            queue_cmd(CMD_RUN, 1'($urandom_range(0, 1)));
         end else begin
            queue_cmd(3'($urandom_range(CMD_RUN + 1, CMD_LAST_CODE)),
                      1'($urandom_range(0, 1)));
         end
      end
   endtask

   task automatic drain_pipe();
      while (cmd_backlog.size() != 0 || req_valid || pending_outputs.size() != 0)
         @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   initial begin
      cfg.spin_direction = SPIN_DIR_RESET;
      cfg.start_duty     = START_DUTY_RESET;
      cfg.lock_count     = LOCK_COUNT_RESET;
      cfg.timeout_ticks  = TIMEOUT_RESET;
      m_step   = 3'd0;
      m_gates  = 6'd0;
      m_sense  = PHASE_U;
      m_pulses = 8'd0;
      m_idle   = 16'd0;
      m_target = TARGET_DUTY_RESET;
      m_run    = 1'b0;

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      repeat (2) @(posedge clock);

      // stopped, unknown codes, start, lock and step, forced step, stop and restart
      program_commutator(1'b1, 8'd20, 8'd2, 16'd3);
      queue_cmd(CMD_TOGGLE, 1'b1);
      queue_cmd(CMD_TICK, 1'b0);
      queue_cmd(CMD_SPEED_UP, 1'b1);
      queue_cmd(CMD_SPEED_DOWN, 1'b0);
      queue_cmd(CMD_RUN + 3'd1, 1'b0);
      queue_cmd(CMD_RUN + 3'd2, 1'b1);
      queue_cmd(CMD_LAST_CODE, 1'b1);
      queue_cmd(CMD_RUN, 1'b0);
      queue_cmd(CMD_SPEED_UP, 1'b0);
      queue_cmd(CMD_SPEED_DOWN, 1'b1);
      repeat (3) queue_cmd(CMD_TOGGLE, 1'b0);
      queue_cmd(CMD_TOGGLE, 1'b1);
      repeat (3) queue_cmd(CMD_TICK, 1'b1);
      queue_cmd(CMD_RUN, 1'b1);
      queue_cmd(CMD_RUN, 1'b0);
      repeat (3) queue_cmd(CMD_TICK, 1'b0);
      repeat (2) queue_cmd(CMD_SPEED_DOWN, 1'b0);
      drain_pipe();

      // zero lock count and zero timeout, target below start duty
      program_commutator(1'b0, 8'd255, 8'd0, 16'd0);
      queue_cmd(CMD_TOGGLE, 1'b0);
      queue_cmd(CMD_TOGGLE, 1'b1);
      queue_cmd(CMD_TICK, 1'b1);
      queue_cmd(CMD_SPEED_DOWN, 1'b0);
      queue_cmd(CMD_SPEED_UP, 1'b1);
      queue_cmd(CMD_LAST_CODE, 1'b0);
      drain_pipe();

      for (int p = 0; p < 10; p++) begin
         program_commutator((p == 0) ? 1'b0 : (p == 1) ? 1'b1 : 1'($urandom_range(0, 1)),
                            (p == 1) ? 8'd0 : (p == 2) ? 8'd255 : 8'($urandom_range(0, 60)),
                            (p == 3) ? 8'd255 : (p == 4) ? 8'd1 : 8'($urandom_range(1, 6)),
                            (p == 3 || p == 5) ? 16'hFFFF :
                            (p == 6) ? 16'd1 : 16'($urandom_range(2, 24)));
         queue_random_items((p == 3) ? 350 : 100,
                            (p == 3) ? 85 : 45,
                            (p == 3) ? 2 : (p == 1 || p == 2) ? 14 : 8,
                            (p == 3 || p == 1 || p == 2) ? 2 : 8);
         drain_pipe();
      end

      repeat (8) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
